### src/rfs_pkg.sv
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types, constants and the fade pattern table of the RGB fade
// sequencer.
// ----------------------------------------------------------------------------
package rfs_pkg;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_LOOP_OFF = 2'd1,
        REQ_LOOP_ON  = 2'd2,
        REQ_TOGGLE   = 2'd3
    } req_code_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PWM_PERIOD = 2'd0,
        CFG_LEVEL_HIGH = 2'd1,
        CFG_LEVEL_MID  = 2'd2
    } cfg_addr_t;

    // Pattern table level codes.
    typedef enum logic [1:0] {
        LC_ZERO = 2'd0,
        LC_MID  = 2'd1,
        LC_HIGH = 2'd2
    } lvl_code_t;

    localparam int          STEPS_DEF      = 21;
    localparam int          CFG_IDX_W      = 2;
    localparam int          CFG_DATA_W     = 16;
    localparam int          DUTY_W         = 16;
    localparam int          LVL_W          = 7;
    localparam int          IDX_W          = 5;
    localparam int          MUL_W          = 32;

    localparam logic [15:0] PWM_PERIOD_RST = 16'd1000;
    localparam logic [6:0]  LEVEL_HIGH_RST = 7'd30;
    localparam logic [6:0]  LEVEL_MID_RST  = 7'd15;
    localparam logic [6:0]  BRIGHT_MAX     = 7'd100;

    // x / 10000 == (x * RECIP) >> RECIP_SHIFT, exact for every x below 2**30.
    localparam logic [30:0] RECIP          = 31'd1759218605;
    localparam int          RECIP_SHIFT    = 44;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] brightness;
    } req_t;

    typedef struct packed {
        logic [15:0] red_duty;
        logic [15:0] green_duty;
        logic [15:0] blue_duty;
        logic        duty_valid;
    } rsp_t;

    typedef struct packed {
        logic [15:0] pwm_period;
        logic [6:0]  level_high;
        logic [6:0]  level_mid;
    } cfg_t;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_op_t;

    // Returns the {red, green, blue} level codes of one pattern row.
    function automatic logic [5:0] pattern_row(input logic [IDX_W-1:0] row);
        logic [5:0] codes;
        unique case (row)
            5'd1:    codes = {LC_MID,  LC_ZERO, LC_ZERO};
            5'd2:    codes = {LC_HIGH, LC_ZERO, LC_ZERO};
            5'd4:    codes = {LC_ZERO, LC_MID,  LC_ZERO};
            5'd5:    codes = {LC_ZERO, LC_HIGH, LC_ZERO};
            5'd7:    codes = {LC_ZERO, LC_ZERO, LC_MID};
            5'd8:    codes = {LC_ZERO, LC_ZERO, LC_HIGH};
            5'd10:   codes = {LC_MID,  LC_ZERO, LC_MID};
            5'd11:   codes = {LC_HIGH, LC_ZERO, LC_HIGH};
            5'd13:   codes = {LC_MID,  LC_MID,  LC_ZERO};
            5'd14:   codes = {LC_HIGH, LC_HIGH, LC_ZERO};
            5'd16:   codes = {LC_ZERO, LC_MID,  LC_MID};
            5'd17:   codes = {LC_ZERO, LC_HIGH, LC_HIGH};
            5'd19:   codes = {LC_HIGH, LC_HIGH, LC_HIGH};
            default: codes = {LC_ZERO, LC_ZERO, LC_ZERO};
        endcase
        return codes;
    endfunction

endpackage

### src/rfs_mul.sv
// ----------------------------------------------------------------------------
// rfs_mul
// Shared registered multiplier used for every product of the duty math.
// ----------------------------------------------------------------------------
module rfs_mul
    import rfs_pkg::*;
(
    input  logic                 clk,
    input  mul_op_t              op,
    output logic [2*MUL_W-1:0]   p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= op.a * op.b;
    end

endmodule

### src/rfs_seq.sv
// ----------------------------------------------------------------------------
// rfs_seq
// Sequencer of the fade: level stepping, pattern index, loop mode and the
// per-channel schedule of the shared multiplier.
// ----------------------------------------------------------------------------
module rfs_seq
    import rfs_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  req_t                 req,
    input  cfg_t                 cfg,
    output logic                 busy,
    output mul_op_t              mul_op,
    input  logic [2*MUL_W-1:0]   mul_p,
    output logic                 res_valid,
    output rsp_t                 res,
    input  logic                 res_take
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PB   = 6'b000010,
        S_LV   = 6'b000100,
        S_RC   = 6'b001000,
        S_WR   = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    localparam logic [IDX_W:0] STEPS_L = (IDX_W+1)'(STEPS);

    state_t              state_reg, state_next;
    logic [1:0]          ch_reg, ch_next;
    logic [6:0]          bright_reg, bright_next;
    logic [22:0]         pb_reg, pb_next;
    logic [LVL_W-1:0]    lvl_reg [3];
    logic [LVL_W-1:0]    lvl_next [3];
    logic [DUTY_W-1:0]   duty_reg [3];
    logic [DUTY_W-1:0]   duty_next [3];
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                loop_on_reg, loop_on_next;
    logic                dvalid_reg, dvalid_next;

    logic [1:0]          req_eff;
    logic [IDX_W-1:0]    idx_use;
    logic [IDX_W:0]      idx_inc;
    logic [5:0]          row_codes;
    logic [LVL_W-1:0]    tgt [3];
    logic                all_match;
    logic [16:0]         quot;

    function automatic logic [LVL_W-1:0] code_level(input logic [1:0] code,
                                                    input cfg_t c);
        logic [LVL_W-1:0] lv;
        unique case (code)
            LC_HIGH: lv = c.level_high;
            LC_MID:  lv = c.level_mid;
            default: lv = '0;
        endcase
        return lv;
    endfunction

    assign quot = mul_p[RECIP_SHIFT+16:RECIP_SHIFT];

    always_comb
    begin
        req_eff = req.req_type;
        if (req.req_type == REQ_TOGGLE)
        begin
            req_eff = loop_on_reg ? REQ_LOOP_OFF : REQ_LOOP_ON;
        end

        idx_use   = ({1'b0, idx_reg} >= STEPS_L) ? '0 : idx_reg;
        idx_inc   = {1'b0, idx_use} + 1'b1;
        row_codes = pattern_row(idx_use);
        tgt[0]    = code_level(row_codes[5:4], cfg);
        tgt[1]    = code_level(row_codes[3:2], cfg);
        tgt[2]    = code_level(row_codes[1:0], cfg);
        all_match = (lvl_reg[0] == tgt[0]) && (lvl_reg[1] == tgt[1])
                    && (lvl_reg[2] == tgt[2]);
    end

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        bright_next  = bright_reg;
        pb_next      = pb_reg;
        idx_next     = idx_reg;
        loop_on_next = loop_on_reg;
        dvalid_next  = dvalid_reg;
        for (int i = 0; i < 3; i++)
        begin
            lvl_next[i]  = lvl_reg[i];
            duty_next[i] = duty_reg[i];
        end
        mul_op = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DONE;
                    if (req_eff == REQ_LOOP_OFF)
                    begin
                        loop_on_next = 1'b0;
                        dvalid_next  = 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            duty_next[i] = '0;
                        end
                    end
                    else if (req_eff == REQ_LOOP_ON)
                    begin
                        loop_on_next = 1'b1;
                        dvalid_next  = 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            duty_next[i] = cfg.pwm_period;
                        end
                    end
                    else if (!loop_on_reg)
                    begin
                        dvalid_next = 1'b0;
                        for (int i = 0; i < 3; i++)
                        begin
                            duty_next[i] = '0;
                        end
                    end
                    else
                    begin
                        state_next  = S_PB;
                        ch_next     = 2'd0;
                        dvalid_next = 1'b1;
                        bright_next = (req.brightness > BRIGHT_MAX) ? BRIGHT_MAX
                                                                    : req.brightness;
                        for (int i = 0; i < 3; i++)
                        begin
                            if (lvl_reg[i] < tgt[i])
                            begin
                                lvl_next[i] = lvl_reg[i] + 1'b1;
                            end
                            else if (lvl_reg[i] > tgt[i])
                            begin
                                lvl_next[i] = lvl_reg[i] - 1'b1;
                            end
                        end
                        if (all_match)
                        begin
                            idx_next = (idx_inc >= STEPS_L) ? '0 : idx_inc[IDX_W-1:0];
                        end
                        else
                        begin
                            idx_next = idx_use;
                        end
                    end
                end
            end
            S_PB:
            begin
                mul_op.a   = MUL_W'(cfg.pwm_period);
                mul_op.b   = MUL_W'(bright_reg);
                state_next = S_LV;
            end
            S_LV:
            begin
                // The first channel takes period * brightness straight from the
                // multiplier and keeps it for the other two.
                if (ch_reg == 2'd0)
                begin
                    pb_next  = mul_p[22:0];
                    mul_op.a = MUL_W'(mul_p[22:0]);
                end
                else
                begin
                    mul_op.a = MUL_W'(pb_reg);
                end
                mul_op.b   = MUL_W'(lvl_reg[ch_reg]);
                state_next = S_RC;
            end
            S_RC:
            begin
                mul_op.a   = MUL_W'(mul_p[29:0]);
                mul_op.b   = MUL_W'(RECIP);
                state_next = S_WR;
            end
            S_WR:
            begin
                duty_next[ch_reg] = quot[16] ? '1 : quot[15:0];
                if (ch_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_LV;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ch_reg      <= 2'd0;
            idx_reg     <= '0;
            loop_on_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                lvl_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            idx_reg     <= idx_next;
            loop_on_reg <= loop_on_next;
            for (int i = 0; i < 3; i++)
            begin
                lvl_reg[i] <= lvl_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bright_reg <= bright_next;
        pb_reg     <= pb_next;
        dvalid_reg <= dvalid_next;
        for (int i = 0; i < 3; i++)
        begin
            duty_reg[i] <= duty_next[i];
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign res_valid      = (state_reg == S_DONE);
    assign res.red_duty   = duty_reg[0];
    assign res.green_duty = duty_reg[1];
    assign res.blue_duty  = duty_reg[2];
    assign res.duty_valid = dvalid_reg;

endmodule

### src/rgb_fade_sequencer.sv
// ----------------------------------------------------------------------------
// rgb_fade_sequencer
// RGB LED color-fade sequencer with PWM duty computation.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the req channel (req_valid / req_stall / req). Each
// request is a fade tick carrying a brightness, or a loop off, loop on or
// loop toggle command. Every request yields exactly one transfer on the rsp
// channel (rsp_valid / rsp_stall / rsp) with the three PWM compare values.
// A mode command, or a tick while the loop is off, goes straight to the done
// state, from which its result is loaded into the output register. A tick
// while looping runs ten passes of the shared multiplier sequence (one for
// period * brightness, then three per color: times level, times the
// reciprocal of 10000, write back) before it reaches the done state.
// req_stall is high while a request is in progress. A finished result waits
// in the output register while rsp_stall is high; the next request is still
// taken and held in its last step until the output register frees up.
// Reset clears the levels and pattern index, turns the loop on and loads the
// default registers. The user writes registers through cfg_we / cfg_index /
// cfg_data only while no request is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgb_fade_sequencer
    import rfs_pkg::*;
#(
    parameter int STEPS = STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  req_t                    req,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output rsp_t                    rsp,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t                 cfg_reg;
    rsp_t                 rsp_reg;
    logic                 rsp_valid_reg;
    logic                 busy;
    logic                 start;
    mul_op_t              mul_op;
    logic [2*MUL_W-1:0]   mul_p;
    logic                 res_valid;
    rsp_t                 res;
    logic                 res_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pwm_period <= PWM_PERIOD_RST;
            cfg_reg.level_high <= LEVEL_HIGH_RST;
            cfg_reg.level_mid  <= LEVEL_MID_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PWM_PERIOD: cfg_reg.pwm_period <= cfg_data;
                CFG_LEVEL_HIGH: cfg_reg.level_high <= cfg_data[LVL_W-1:0];
                CFG_LEVEL_MID:  cfg_reg.level_mid  <= cfg_data[LVL_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign start     = req_valid && !busy;
    assign req_stall = busy;
    assign res_take  = res_valid && (!rsp_valid_reg || !rsp_stall);

    rfs_mul u_mul (
        .clk   (clk),
        .op    (mul_op),
        .p_reg (mul_p)
    );

    rfs_seq #(
        .STEPS (STEPS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .cfg       (cfg_reg),
        .busy      (busy),
        .mul_op    (mul_op),
        .mul_p     (mul_p),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    // Output register: loads when empty or when its current transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### src/rfs_checker.sv
// ----------------------------------------------------------------------------
// rfs_checker
// Port-level checks of the RGB fade sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rfs_checker
    import rfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    input  logic                    req_stall,
    input  req_t                    req,
    input  logic                    rsp_valid,
    input  logic                    rsp_stall,
    input  rsp_t                    rsp
);

    // A stalled result holds until its transfer.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // The block is busy in the cycle after taking a request.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken without going busy");

    // A new result only follows work on a request.
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without a request in progress");

    // A result without updated duties carries zero duties.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.duty_valid |->
            rsp.red_duty == '0 && rsp.green_duty == '0 && rsp.blue_duty == '0)
        else $error("non-updating result with nonzero duty");

endmodule

bind rgb_fade_sequencer rfs_checker u_rfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB fade sequencer. An in-bench predictor
// tracks the color levels, the pattern position and the loop mode, and it
// works out the three duties of every request. Directed requests cover the
// mode commands and the register extremes. Random phases under changing
// register settings follow, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import rfs_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int FADE_STEPS    = 21;
    localparam int PHASE_ITEMS   = 140;
    localparam int MAX_PRINTED   = 30;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PWM_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and of the sequencer state.
    logic [15:0] period_q;
    logic [6:0]  level_high_q;
    logic [6:0]  level_mid_q;
    logic [6:0]  fade_level [3];
    logic [4:0]  fade_row;
    logic        loop_running;

    rsp_t duty_queue [$];

    int cycle_count     = 0;
    int mismatches      = 0;
    int items_sent      = 0;
    int effective_items = 0;
    int ignored_ticks   = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int pattern_wraps   = 0;
    int saturated       = 0;
    int burst_left      = 0;

    int stall_mode       = 0;
    int stall_run        = 0;
    int stall_phase_left = 0;

    always #1 clk = ~clk;

    rgb_fade_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic reset_predictor();
        period_q     = PWM_PERIOD_RST;
        level_high_q = LEVEL_HIGH_RST;
        level_mid_q  = LEVEL_MID_RST;
        for (int c = 0; c < 3; c++)
            fade_level[c] = '0;
        fade_row     = '0;
        loop_running = 1'b1;
    endtask

    // Rows 0 to 17 come in triples of off, mid and high, each triple lighting
    // one color combination. Row 19 is all high and every other row is off.
    function automatic logic [6:0] fade_target(input logic [4:0] row, input int color);
        logic [2:0]  lit;
        lvl_code_t   strength;
        int unsigned pos;
        pos      = row;
        lit      = 3'b000;
        strength = LC_ZERO;
        if (pos == 19)
        begin
            lit      = 3'b111;
            strength = LC_HIGH;
        end
        else if (pos < 18)
        begin
            strength = lvl_code_t'(pos % 3);
            case (pos / 3)
                0:       lit = 3'b100;
                1:       lit = 3'b010;
                2:       lit = 3'b001;
                3:       lit = 3'b101;
                4:       lit = 3'b110;
                default: lit = 3'b011;
            endcase
        end
        if (!lit[2 - color])
            return '0;
        case (strength)
            LC_HIGH: return level_high_q;
            LC_MID:  return level_mid_q;
            default: return '0;
        endcase
    endfunction

    function automatic logic [15:0] scaled_duty(input logic [6:0] bright, input logic [6:0] lvl);
        longint unsigned product;
        product = period_q;
        product = product * bright;
        product = product * lvl;
        product = product / 10000;
        if (product > 65535)
        begin
            saturated++;
            return 16'hFFFF;
        end
        return product[15:0];
    endfunction

    // Applies one request to the predictor state and returns its result.
    function automatic rsp_t advance_fade(input req_t r);
        rsp_t       out;
        req_code_t  kind;
        logic [6:0] bright;
        logic [6:0] target;
        int         matched;
        out     = '0;
        matched = 0;
        kind    = req_code_t'(r.req_type);
        if (kind == REQ_TOGGLE)
            kind = loop_running ? REQ_LOOP_OFF : REQ_LOOP_ON;
        if (kind == REQ_TICK && !loop_running)
        begin
            ignored_ticks++;
            return out;
        end
        effective_items++;
        out.duty_valid = 1'b1;
        if (kind == REQ_LOOP_OFF)
        begin
            loop_running = 1'b0;
        end
        else if (kind == REQ_LOOP_ON)
        begin
            loop_running   = 1'b1;
            out.red_duty   = period_q;
            out.green_duty = period_q;
            out.blue_duty  = period_q;
        end
        else
        begin
            bright = (r.brightness > BRIGHT_MAX) ? BRIGHT_MAX : r.brightness;
            if (fade_row >= FADE_STEPS)
                fade_row = '0;
            for (int c = 0; c < 3; c++)
            begin
                target = fade_target(fade_row, c);
                if (fade_level[c] == target)
                    matched++;
                else if (fade_level[c] < target)
                    fade_level[c] = fade_level[c] + 7'd1;
                else
                    fade_level[c] = fade_level[c] - 7'd1;
            end
            if (matched == 3)
            begin
                fade_row = fade_row + 5'd1;
                if (fade_row >= FADE_STEPS)
                begin
                    fade_row = '0;
                    pattern_wraps++;
                end
            end
            out.red_duty   = scaled_duty(bright, fade_level[0]);
            out.green_duty = scaled_duty(bright, fade_level[1]);
            out.blue_duty  = scaled_duty(bright, fade_level[2]);
        end
        return out;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("tb: mismatch on %s: got %0d, expected %0d at %0t",
                     what, got, want, $time);
    endtask

    // Result checker: every transfer on the response side is matched against
    // the oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (duty_queue.size() == 0)
            begin
                flag_mismatch("unexpected result, red_duty", rsp.red_duty, 16'd0);
            end
            else
            begin
                want = duty_queue.pop_front();
                results_checked++;
                if (rsp.red_duty !== want.red_duty)
                    flag_mismatch("red_duty", rsp.red_duty, want.red_duty);
                if (rsp.green_duty !== want.green_duty)
                    flag_mismatch("green_duty", rsp.green_duty, want.green_duty);
                if (rsp.blue_duty !== want.blue_duty)
                    flag_mismatch("blue_duty", rsp.blue_duty, want.blue_duty);
                if (rsp.duty_valid !== want.duty_valid)
                    flag_mismatch("duty_valid", {15'd0, rsp.duty_valid},
                                  {15'd0, want.duty_valid});
            end
        end
    end

    // Receiver stall pattern: phases of no stall, light stall, heavy stall
    // and long stall runs.
    always @(negedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode       = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(50, 300);
        end
        stall_phase_left--;
        if (stall_run > 0)
        begin
            stall_run--;
        end
        else
        begin
            case (stall_mode)
                0:
                begin
                    rsp_stall = 1'b0;
                    stall_run = 20;
                end
                1:
                begin
                    rsp_stall = ($urandom_range(0, 3) == 0);
                    stall_run = $urandom_range(0, 2);
                end
                2:
                begin
                    rsp_stall = ($urandom_range(0, 3) != 0);
                    stall_run = $urandom_range(0, 3);
                end
                default:
                begin
                    rsp_stall = ~rsp_stall;
                    stall_run = rsp_stall ? $urandom_range(5, 24) : $urandom_range(0, 6);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sends one request and records its prediction at the transfer. Valid
    // stays high after the transfer while a burst is running, so the next
    // call just replaces the payload.
    task automatic send_request(input req_code_t kind, input logic [6:0] bright);
        req.req_type   = kind;
        req.brightness = bright;
        req_valid      = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        duty_queue.push_back(advance_fade(req));
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_random_item();
        int          pick;
        logic [6:0]  bright;
        pick   = $urandom_range(0, 99);
        bright = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(0, 100));
        if (pick < 88)
            send_request(REQ_TICK, bright);
        else if (pick < 91)
            send_request(REQ_LOOP_OFF, bright);
        else if (pick < 95)
            send_request(REQ_LOOP_ON, bright);
        else
            send_request(REQ_TOGGLE, bright);
    endtask

    // Waits until every predicted result has arrived and the block is idle.
    task automatic settle();
        req_valid  = 1'b0;
        burst_left = 0;
        while (duty_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_addr_t idx, input logic [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        reg_writes++;
        case (idx)
            CFG_PWM_PERIOD: period_q     = value;
            CFG_LEVEL_HIGH: level_high_q = value[6:0];
            CFG_LEVEL_MID:  level_mid_q  = value[6:0];
            default:        ;
        endcase
    endtask

    // Mode commands and ticks with the reset register values.
    task automatic test_mode_commands();
        send_request(REQ_TICK, 7'd100);
        send_request(REQ_TICK, 7'd127);
        send_request(REQ_TICK, 7'd0);
        send_request(REQ_TICK, 7'd64);
        send_request(REQ_TOGGLE, 7'd100);
        send_request(REQ_TICK, 7'd77);
        send_request(REQ_LOOP_OFF, 7'd0);
        send_request(REQ_TICK, 7'd100);
        send_request(REQ_TOGGLE, 7'd127);
        send_request(REQ_LOOP_ON, 7'd5);
        send_request(REQ_TICK, 7'd100);
        send_request(REQ_LOOP_OFF, 7'd100);
        send_request(REQ_LOOP_ON, 7'd0);
        send_request(REQ_TICK, 7'd101);
    endtask

    // Smallest and largest period, and level writes whose upper data bits
    // must be dropped.
    task automatic test_register_extremes();
        settle();
        write_reg(CFG_PWM_PERIOD, 16'd1);
        write_reg(CFG_LEVEL_HIGH, 16'd0);
        write_reg(CFG_LEVEL_MID, 16'h0080);
        send_request(REQ_TICK, 7'd100);
        send_request(REQ_TICK, 7'd127);
        send_request(REQ_LOOP_ON, 7'd0);
        settle();
        write_reg(CFG_PWM_PERIOD, 16'hFFFF);
        write_reg(CFG_LEVEL_HIGH, 16'd100);
        write_reg(CFG_LEVEL_MID, 16'hFF81);
        send_request(REQ_TICK, 7'd100);
        send_request(REQ_TICK, 7'd127);
        send_request(REQ_TOGGLE, 7'd0);
        send_request(REQ_TOGGLE, 7'd0);
    endtask

    // Levels above 100 with full period drive the duties past 16 bits.
    task automatic test_duty_saturation();
        int stop_at;
        settle();
        write_reg(CFG_PWM_PERIOD, 16'hFFFF);
        write_reg(CFG_LEVEL_HIGH, 16'hFFFF);
        write_reg(CFG_LEVEL_MID, 16'hFFFF);
        send_request(REQ_LOOP_ON, 7'd0);
        stop_at = effective_items + 200;
        while (effective_items < stop_at)
            send_request(REQ_TICK, 7'($urandom_range(90, 127)));
    endtask

    // Random traffic under a new register setting per phase. Small levels
    // let the pattern wrap often; the extreme settings hit the corners.
    task automatic test_random_phases();
        int          stop_at;
        logic [15:0] period;
        logic [15:0] high;
        logic [15:0] mid;
        for (int phase = 0; phase < 7; phase++)
        begin
            settle();
            period = 16'($urandom_range(1, 65535));
            high   = 16'($urandom);
            mid    = 16'($urandom);
            case (phase % 4)
                0:
                begin
                    high = {9'($urandom), 7'($urandom_range(0, 4))};
                    mid  = {9'($urandom), 7'($urandom_range(0, 3))};
                end
                1:
                begin
                    period = $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
                    high   = $urandom_range(0, 1) ? 16'd127 : 16'd0;
                    mid    = $urandom_range(0, 1) ? 16'd100 : 16'd1;
                end
                2:
                begin
                    high = 16'($urandom_range(0, 40));
                    mid  = 16'($urandom_range(0, 40));
                end
                default: ;
            endcase
            write_reg(CFG_LEVEL_MID, mid);
            write_reg(CFG_PWM_PERIOD, period);
            write_reg(CFG_LEVEL_HIGH, high);
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
                send_random_item();
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_mode_commands();
        test_register_extremes();
        test_duty_saturation();
        test_random_phases();
        settle();
        $display("tb: %0d requests sent (%0d ticks while stopped), %0d results checked,",
                 items_sent, ignored_ticks, results_checked);
        $display("tb: %0d register writes, pattern wrapped %0d times, %0d saturated duties",
                 reg_writes, pattern_wraps, saturated);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
